// ===== sv/rti_pkg.sv =====
`default_nettype none

package rti_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int IDXE_W      = IDX_W + 1;
    localparam int CNT_W       = 7;

    // Fixed point of the interpolation fraction
    localparam int FRAC_W    = 16;
    localparam int QUO_W     = FRAC_W + 1;
    localparam int DIV_CNT_W = $clog2(QUO_W);

    // Difference and product widths for the interpolation step
    localparam int VAL_W  = 32;
    localparam int DIFF_W = VAL_W + 1;
    localparam int PROD_W = DIFF_W + QUO_W + 1;

    // Stream payload widths
    localparam int S_DATA_W = 136;
    localparam int S_USER_W = 1;
    localparam int M_DATA_W = 96;
    localparam int M_USER_W = 1;

    typedef enum logic [0:0] {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } opcode_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK_LO,
        S_CHK_HI,
        S_SEARCH,
        S_CMP,
        S_PREP,
        S_DIV,
        S_DIFF,
        S_MUL_E,
        S_MUL_F,
        S_ADD_F,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [VAL_W-1:0]        range_val;
        logic signed [VAL_W-1:0] elevation;
        logic [VAL_W-1:0]        flight_time;
    } entry_t;

endpackage

`default_nettype wire

// ===== sv/range_table_interpolator.sv =====
`default_nettype none
// Write item: written to the table on its transfer; writes can transfer back to back.
// Query clamped at an end of the table: after S_CHK_LO and S_CHK_HI, S_OUT registers the result.
// Query inside the table: binary search (a table read in S_SEARCH, a compare in S_CMP per step),
// then the 17-step shared restoring divider, S_DIFF, S_MUL_E, S_MUL_F, S_ADD_F and S_OUT.
// The next item transfers once the result is registered; none is taken while a query runs.
// Reset (rst_n low, asynchronous): control idle, entries_in_use = 2, table contents kept.

module range_table_interpolator (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [rti_pkg::CNT_W-1:0]      cfg_wr_data,   // entries_in_use
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [5:0] entry_index, [37:6] entry_range, [69:38] entry_elevation,
    // [101:70] entry_flight_time, [133:102] query_distance, [135:134] zero
    input  wire logic [rti_pkg::S_DATA_W-1:0]   s_axis_tdata,
    input  wire logic [rti_pkg::S_USER_W-1:0]   s_axis_tuser,  // [0] opcode
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [31:0] solution_range, [63:32] solution_elevation, [95:64] solution_flight_time
    output logic [rti_pkg::M_DATA_W-1:0]        m_axis_tdata,
    output logic [rti_pkg::M_USER_W-1:0]        m_axis_tuser   // [0] in_range
);
    import rti_pkg::*;

    // Input fields
    logic [5:0]       in_entry_index;
    entry_t           in_entry;
    logic [VAL_W-1:0] in_query_distance;
    opcode_t          in_opcode;

    assign in_entry_index        = s_axis_tdata[5:0];
    assign in_entry.range_val    = s_axis_tdata[37:6];
    assign in_entry.elevation    = s_axis_tdata[69:38];
    assign in_entry.flight_time  = s_axis_tdata[101:70];
    assign in_query_distance     = s_axis_tdata[133:102];
    assign in_opcode             = opcode_t'(s_axis_tuser[0]);

    // Control state
    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       entries_reg;
    logic                   m_valid_reg, m_valid_next;

    // Work registers
    logic [VAL_W-1:0]         dist_reg, dist_next;
    logic [IDX_W-1:0]         lo_idx_reg, lo_idx_next;
    logic [IDX_W-1:0]         hi_idx_reg, hi_idx_next;
    entry_t                   lo_ent_reg, lo_ent_next;
    entry_t                   hi_ent_reg, hi_ent_next;
    logic [VAL_W-1:0]         rem_reg, rem_next;
    logic [VAL_W-1:0]         span_reg, span_next;
    logic [QUO_W-1:0]         quo_reg, quo_next;
    logic [DIV_CNT_W-1:0]     div_cnt_reg, div_cnt_next;
    logic signed [DIFF_W-1:0] diff_e_reg, diff_e_next;
    logic signed [DIFF_W-1:0] diff_f_reg, diff_f_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [VAL_W-1:0]         res_range_reg, res_range_next;
    logic [VAL_W-1:0]         res_elev_reg, res_elev_next;
    logic [VAL_W-1:0]         res_ft_reg, res_ft_next;
    logic                     res_inr_reg, res_inr_next;
    logic [M_DATA_W-1:0]      out_data_reg, out_data_next;
    logic                     out_inr_reg, out_inr_next;

    // Table memory
    entry_t                 table_mem [TABLE_DEPTH];
    entry_t                 rd_data_reg;
    logic [IDX_W-1:0]       rd_addr;
    logic                   mem_we;

    // Helpers
    logic                     s_xfer;
    logic [IDX_W-1:0]         hi_clamp;
    logic [IDXE_W-1:0]        mid_sum;
    logic [IDX_W-1:0]         mid_idx;
    logic                     lo_hi_gap;
    logic                     new_gap;
    logic [VAL_W:0]           div_cand;
    logic [VAL_W:0]           div_sub;
    logic                     div_ge;
    logic signed [DIFF_W-1:0] mul_a;
    logic signed [QUO_W:0]    mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [PROD_W-1:0] step_val;
    logic signed [PROD_W-1:0] lerp_sum_e;
    logic signed [PROD_W-1:0] lerp_sum_f;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_xfer        = s_axis_tvalid && s_axis_tready;
    assign mem_we        = s_xfer && (in_opcode == OP_WRITE)
                           && (32'(in_entry_index) < TABLE_DEPTH);

    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_inr_reg;

    // Last entry in use, clamped to the table
    always_comb
    begin
        if (entries_reg < CNT_W'(2))
            hi_clamp = IDX_W'(1);
        else if (32'(entries_reg) > TABLE_DEPTH)
            hi_clamp = IDX_W'(TABLE_DEPTH - 1);
        else
            hi_clamp = IDX_W'(entries_reg - CNT_W'(1));
    end

    // Search midpoint and bracket width
    assign mid_sum   = {1'b0, lo_idx_reg} + {1'b0, hi_idx_reg};
    assign mid_idx   = mid_sum[IDX_W:1];
    assign lo_hi_gap = ({1'b0, lo_idx_reg} + IDXE_W'(1)) < {1'b0, hi_idx_reg};

    // Table read address
    always_comb
    begin
        case (state_reg)
            S_IDLE:   rd_addr = '0;
            S_CHK_LO: rd_addr = hi_idx_reg;
            default:  rd_addr = mid_idx;
        endcase
    end

    // Shared divider step: first step compares the numerator, later ones shift first
    assign div_cand = (div_cnt_reg == '0) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
    assign div_sub  = div_cand - {1'b0, span_reg};
    assign div_ge   = (span_reg != '0) && (div_cand >= {1'b0, span_reg});

    // Shared multiplier: elevation difference first, then flight time difference
    assign mul_a = (state_reg == S_MUL_E) ? diff_e_reg : diff_f_reg;
    assign mul_b = $signed({1'b0, quo_reg});
    assign mul_p = mul_a * mul_b;

    // Floor of the scaled product added to the low entry value
    assign step_val   = prod_reg >>> FRAC_W;
    assign lerp_sum_e = step_val
                        + $signed({{(PROD_W-VAL_W){lo_ent_reg.elevation[VAL_W-1]}},
                                   lo_ent_reg.elevation});
    assign lerp_sum_f = step_val + $signed({{(PROD_W-VAL_W){1'b0}}, lo_ent_reg.flight_time});

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        dist_next      = dist_reg;
        lo_idx_next    = lo_idx_reg;
        hi_idx_next    = hi_idx_reg;
        lo_ent_next    = lo_ent_reg;
        hi_ent_next    = hi_ent_reg;
        rem_next       = rem_reg;
        span_next      = span_reg;
        quo_next       = quo_reg;
        div_cnt_next   = div_cnt_reg;
        diff_e_next    = diff_e_reg;
        diff_f_next    = diff_f_reg;
        prod_next      = prod_reg;
        res_range_next = res_range_reg;
        res_elev_next  = res_elev_reg;
        res_ft_next    = res_ft_reg;
        res_inr_next   = res_inr_reg;
        out_data_next  = out_data_reg;
        out_inr_next   = out_inr_reg;
        new_gap        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_xfer && in_opcode == OP_QUERY)
                begin
                    dist_next   = in_query_distance;
                    lo_idx_next = '0;
                    hi_idx_next = hi_clamp;
                    state_next  = S_CHK_LO;
                end
            end

            S_CHK_LO:
            begin
                lo_ent_next = rd_data_reg;
                state_next  = S_CHK_HI;
            end

            S_CHK_HI:
            begin
                hi_ent_next = rd_data_reg;
                if (dist_reg < lo_ent_reg.range_val)
                begin
                    res_range_next = lo_ent_reg.range_val;
                    res_elev_next  = lo_ent_reg.elevation;
                    res_ft_next    = lo_ent_reg.flight_time;
                    res_inr_next   = 1'b0;
                    state_next     = S_OUT;
                end
                else if (dist_reg > rd_data_reg.range_val)
                begin
                    res_range_next = rd_data_reg.range_val;
                    res_elev_next  = rd_data_reg.elevation;
                    res_ft_next    = rd_data_reg.flight_time;
                    res_inr_next   = 1'b0;
                    state_next     = S_OUT;
                end
                else if (lo_hi_gap)
                    state_next = S_SEARCH;
                else
                    state_next = S_PREP;
            end

            S_SEARCH:
            begin
                state_next = S_CMP;
            end

            // Narrow the bracket with the midpoint entry
            S_CMP:
            begin
                if (dist_reg >= rd_data_reg.range_val)
                begin
                    lo_idx_next = mid_idx;
                    lo_ent_next = rd_data_reg;
                end
                else
                begin
                    hi_idx_next = mid_idx;
                    hi_ent_next = rd_data_reg;
                end
                new_gap    = ({1'b0, lo_idx_next} + IDXE_W'(1)) < {1'b0, hi_idx_next};
                state_next = new_gap ? S_SEARCH : S_PREP;
            end

            S_PREP:
            begin
                rem_next     = dist_reg - lo_ent_reg.range_val;
                span_next    = hi_ent_reg.range_val - lo_ent_reg.range_val;
                quo_next     = '0;
                div_cnt_next = '0;
                state_next   = S_DIV;
            end

            // One quotient bit per cycle
            S_DIV:
            begin
                rem_next     = div_ge ? div_sub[VAL_W-1:0] : div_cand[VAL_W-1:0];
                quo_next     = {quo_reg[QUO_W-2:0], div_ge};
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(QUO_W - 1))
                    state_next = S_DIFF;
            end

            S_DIFF:
            begin
                diff_e_next = $signed({hi_ent_reg.elevation[VAL_W-1], hi_ent_reg.elevation})
                              - $signed({lo_ent_reg.elevation[VAL_W-1], lo_ent_reg.elevation});
                diff_f_next = $signed({1'b0, hi_ent_reg.flight_time})
                              - $signed({1'b0, lo_ent_reg.flight_time});
                state_next  = S_MUL_E;
            end

            S_MUL_E:
            begin
                prod_next  = mul_p;
                state_next = S_MUL_F;
            end

            S_MUL_F:
            begin
                res_elev_next = lerp_sum_e[VAL_W-1:0];
                prod_next     = mul_p;
                state_next    = S_ADD_F;
            end

            S_ADD_F:
            begin
                res_ft_next    = lerp_sum_f[VAL_W-1:0];
                res_range_next = dist_reg;
                res_inr_next   = 1'b1;
                state_next     = S_OUT;
            end

            // Hand the result to the output register once it is free
            S_OUT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next  = 1'b1;
                    out_data_next = {res_ft_reg, res_elev_reg, res_range_reg};
                    out_inr_next  = res_inr_reg;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            entries_reg <= CNT_W'(2);
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en)
                entries_reg <= cfg_wr_data;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        dist_reg      <= dist_next;
        lo_idx_reg    <= lo_idx_next;
        hi_idx_reg    <= hi_idx_next;
        lo_ent_reg    <= lo_ent_next;
        hi_ent_reg    <= hi_ent_next;
        rem_reg       <= rem_next;
        span_reg      <= span_next;
        quo_reg       <= quo_next;
        div_cnt_reg   <= div_cnt_next;
        diff_e_reg    <= diff_e_next;
        diff_f_reg    <= diff_f_next;
        prod_reg      <= prod_next;
        res_range_reg <= res_range_next;
        res_elev_reg  <= res_elev_next;
        res_ft_reg    <= res_ft_next;
        res_inr_reg   <= res_inr_next;
        out_data_reg  <= out_data_next;
        out_inr_reg   <= out_inr_next;
    end

    // Table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            table_mem[IDX_W'(in_entry_index)] <= in_entry;
        rd_data_reg <= table_mem[rd_addr];
    end

    // Checks
    a_search_bracket: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> (lo_idx_reg < hi_idx_reg))
        else $error("search entered with an empty bracket");

    a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_xfer && in_opcode == OP_QUERY) |=> (state_reg == S_CHK_LO))
        else $error("query transfer did not start a lookup");

    a_fraction_max: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIFF) |-> (quo_reg <= QUO_W'(1 << FRAC_W)))
        else $error("interpolation fraction above one");

    a_rem_below_span: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && div_cnt_reg != '0 && span_reg != '0) |-> (rem_reg < span_reg))
        else $error("divider remainder not below span");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && m_valid_reg && !m_axis_tready) |=> (state_reg == S_OUT))
        else $error("result left sequencer while output was full");

endmodule

`default_nettype wire
